@@ design/fgr_pkg.sv @@
// ----------------------------------------------------------------------------
// fgr_pkg
// Shared constants, cell layout and the interface types between the
// top level, the rain grid engine and its random number unit.
// ----------------------------------------------------------------------------
package fgr_pkg;

   localparam int GRID_COLS   = 40;
   localparam int GRID_ROWS   = 25;
   localparam int CELLS       = GRID_COLS * GRID_ROWS;
   localparam int BOTTOM_BASE = (GRID_ROWS - 1) * GRID_COLS;

   localparam int CELL_AW  = $clog2(CELLS);
   localparam int COL_W    = $clog2(GRID_COLS);

   localparam int CNT_W    = 4;
   localparam int GLYPH_W  = 7;
   localparam int ROW_IN_W = 5;
   localparam int COL_IN_W = 6;
   localparam int CFG_W    = 4;
   localparam int CSR_AW   = 1;

   localparam int LFSR_W     = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam int GLYPH_MOD  = 93;
   localparam int GLYPH_BASE = 33;
   localparam int CNT_MAX    = 15;

   localparam int DIV_MAX = (GRID_COLS > GLYPH_MOD) ? GRID_COLS : GLYPH_MOD;
   localparam int DIV_W   = $clog2(DIV_MAX + 1);

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CSR_AW-1:0] CSR_MIN_LENGTH  = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_LENGTH_SPAN = 1'b1;

   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic [GLYPH_W-1:0] glyph;
   } cell_type;

   typedef enum logic [1:0] {
      OP_GLYPH = 2'd0,
      OP_COL   = 2'd1,
      OP_LEN   = 2'd2
   } rand_op_type;

   typedef struct packed {
      logic        start;
      rand_op_type op;
   } rand_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] value;
   } rand_rsp_type;

   typedef struct packed {
      logic                accept;
      logic                cmd;
      logic [ROW_IN_W-1:0] row;
      logic [COL_IN_W-1:0] col;
   } eng_req_type;

   typedef struct packed {
      logic               valid;
      logic [GLYPH_W-1:0] glyph;
      logic [CNT_W-1:0]   remaining;
   } rd_rsp_type;

endpackage

@@ design/fgr_rand.sv @@
// ----------------------------------------------------------------------------
// fgr_rand
// Fibonacci LFSR with a bit-serial remainder unit. A draw advances the
// LFSR by one, three or four steps, then reduces it by the chosen divisor.
// ----------------------------------------------------------------------------
module fgr_rand (
   input  logic                       clock,
   input  logic                       reset,
   input  fgr_pkg::rand_req_type      rand_req,
   input  logic [fgr_pkg::CFG_W-1:0]  min_length,
   input  logic [fgr_pkg::CFG_W-1:0]  length_span,
   output fgr_pkg::rand_rsp_type      rand_rsp
);

   localparam int CNT_IT_W = $clog2(fgr_pkg::LFSR_W);

   logic [fgr_pkg::LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic [fgr_pkg::LFSR_W-1:0] dvd_ff, dvd_in;
   logic [fgr_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [fgr_pkg::DIV_W-1:0]  div_ff, div_in;
   logic [fgr_pkg::DIV_W-1:0]  value_ff, value_in;
   logic [CNT_IT_W-1:0]        iter_ff, iter_in;
   fgr_pkg::rand_op_type       op_ff, op_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   logic [fgr_pkg::LFSR_W-1:0] s1, s2, s3, s4, adv;
   logic [fgr_pkg::DIV_W:0]    trial;
   logic [fgr_pkg::DIV_W-1:0]  rem_next;
   logic [fgr_pkg::DIV_W-1:0]  len_sum;

   function automatic logic [fgr_pkg::LFSR_W-1:0] lfsr_step(
      input logic [fgr_pkg::LFSR_W-1:0] v
   );
      logic b;
      b = v[0] ^ v[2] ^ v[3] ^ v[5];
      return {b, v[fgr_pkg::LFSR_W-1:1]};
   endfunction

   always_comb begin
      s1 = lfsr_step(lfsr_ff);
      s2 = lfsr_step(s1);
      s3 = lfsr_step(s2);
      s4 = lfsr_step(s3);

      trial = {rem_ff, dvd_ff[fgr_pkg::LFSR_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_next = fgr_pkg::DIV_W'(trial - {1'b0, div_ff});
      end else begin
         rem_next = trial[fgr_pkg::DIV_W-1:0];
      end
      len_sum = rem_next + fgr_pkg::DIV_W'(min_length);

      lfsr_in  = lfsr_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      value_in = value_ff;
      iter_in  = iter_ff;
      op_in    = op_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      adv      = s1;

      if (rand_req.start && !busy_ff) begin
         unique case (rand_req.op)
            fgr_pkg::OP_GLYPH: begin
               adv    = s3;
               div_in = fgr_pkg::DIV_W'(fgr_pkg::GLYPH_MOD);
            end
            fgr_pkg::OP_COL: begin
               adv    = s4;
               div_in = fgr_pkg::DIV_W'(fgr_pkg::GRID_COLS);
            end
            fgr_pkg::OP_LEN: begin
               adv    = s1;
               div_in = (length_span == '0) ? fgr_pkg::DIV_W'(1)
                                            : fgr_pkg::DIV_W'(length_span);
            end
            default: begin
               adv    = s1;
               div_in = fgr_pkg::DIV_W'(1);
            end
         endcase
         lfsr_in = adv;
         dvd_in  = adv;
         rem_in  = '0;
         iter_in = '0;
         op_in   = rand_req.op;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = rem_next;
         dvd_in  = {dvd_ff[fgr_pkg::LFSR_W-2:0], 1'b0};
         iter_in = iter_ff + CNT_IT_W'(1);
         if (iter_ff == CNT_IT_W'(fgr_pkg::LFSR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            unique case (op_ff)
               fgr_pkg::OP_GLYPH: value_in = rem_next + fgr_pkg::DIV_W'(fgr_pkg::GLYPH_BASE);
               fgr_pkg::OP_LEN: begin
                  value_in = (len_sum > fgr_pkg::DIV_W'(fgr_pkg::CNT_MAX))
                             ? fgr_pkg::DIV_W'(fgr_pkg::CNT_MAX) : len_sum;
               end
               default: value_in = rem_next;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= fgr_pkg::LFSR_SEED;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         lfsr_ff <= lfsr_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      value_ff <= value_in;
      iter_ff  <= iter_in;
      op_ff    <= op_in;
   end

   assign rand_rsp.busy  = busy_ff;
   assign rand_rsp.done  = done_ff;
   assign rand_rsp.value = value_ff;

endmodule

@@ design/fgr_engine.sv @@
// ----------------------------------------------------------------------------
// fgr_engine
// Cell memory and its sequencer: clearing pass, cell reads, the tick sweep
// through a one-row shift buffer, the flush of the top row and the spawns.
// ----------------------------------------------------------------------------
module fgr_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  fgr_pkg::eng_req_type  req,
   output logic                  req_ready,
   input  logic                  slot_free,
   output fgr_pkg::rd_rsp_type   rd_rsp,
   output fgr_pkg::rand_req_type rand_req,
   input  fgr_pkg::rand_rsp_type rand_rsp
);

   localparam int AW = fgr_pkg::CELL_AW;
   localparam int CW = fgr_pkg::COL_W;

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b000_0000_0001,
      ST_IDLE   = 11'b000_0000_0010,
      ST_RD_OUT = 11'b000_0000_0100,
      ST_SWEEP  = 11'b000_0000_1000,
      ST_FLUSH  = 11'b000_0001_0000,
      ST_SP_COL = 11'b000_0010_0000,
      ST_SP_RD0 = 11'b000_0100_0000,
      ST_SP_RD1 = 11'b000_1000_0000,
      ST_SP_CHK = 11'b001_0000_0000,
      ST_SP_LEN = 11'b010_0000_0000,
      ST_SP_GLY = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   fgr_pkg::cell_type mem [fgr_pkg::CELLS];
   fgr_pkg::cell_type rdata_ff;
   fgr_pkg::cell_type rowbuf_ff [fgr_pkg::GRID_COLS];

   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   logic           iss_pend_ff, iss_pend_in;
   logic [AW-1:0]  iss_addr_ff, iss_addr_in;
   logic [CW-1:0]  iss_col_ff, iss_col_in;
   logic           proc_vld_ff, proc_vld_in;
   logic [AW-1:0]  proc_addr_ff, proc_addr_in;
   logic [CW-1:0]  flush_col_ff, flush_col_in;
   logic           attempt_ff, attempt_in;
   logic [CW-1:0]  sp_col_ff, sp_col_in;
   logic           top_live_ff, top_live_in;
   logic [fgr_pkg::CNT_W-1:0] len_ff, len_in;
   logic           inrange_ff, inrange_in;

   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   fgr_pkg::cell_type   mem_wdata;
   logic                shift_en;
   fgr_pkg::cell_type   shift_data;

   fgr_pkg::cell_type   cur, head, new_cur, new_below;
   logic                bottom, live, below_empty, need_draw, commit, issue;
   logic                req_inrange;
   logic [AW-1:0]       req_addr;

   always_comb begin
      cur         = rdata_ff;
      head        = rowbuf_ff[0];
      bottom      = proc_addr_ff >= AW'(fgr_pkg::BOTTOM_BASE);
      live        = cur.count != '0;
      below_empty = head.count == '0;
      need_draw   = proc_vld_ff && !bottom && live && below_empty;
      commit      = proc_vld_ff && !(need_draw && !rand_rsp.done);
      issue       = iss_pend_ff && (!proc_vld_ff || commit);

      new_cur = cur;
      if (live) begin
         new_cur.count = cur.count - fgr_pkg::CNT_W'(1);
         if (new_cur.count == '0) begin
            new_cur.glyph = '0;
         end
      end
      new_below = head;
      if (live) begin
         new_below.count = cur.count;
         if (below_empty) begin
            new_below.glyph = rand_rsp.value[fgr_pkg::GLYPH_W-1:0];
         end
      end

      req_inrange = (32'(req.row) < fgr_pkg::GRID_ROWS) &&
                    (32'(req.col) < fgr_pkg::GRID_COLS);
      req_addr    = req_inrange ?
                    AW'(32'(req.row) * fgr_pkg::GRID_COLS + 32'(req.col)) : '0;
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      iss_pend_in  = iss_pend_ff;
      iss_addr_in  = iss_addr_ff;
      iss_col_in   = iss_col_ff;
      proc_vld_in  = proc_vld_ff;
      proc_addr_in = proc_addr_ff;
      flush_col_in = flush_col_ff;
      attempt_in   = attempt_ff;
      sp_col_in    = sp_col_ff;
      top_live_in  = top_live_ff;
      len_in       = len_ff;
      inrange_in   = inrange_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      shift_en     = 1'b0;
      shift_data   = new_cur;
      rand_req     = '0;
      rd_rsp       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(fgr_pkg::CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.accept) begin
               if (req.cmd == fgr_pkg::CMD_READ) begin
                  mem_re     = 1'b1;
                  mem_raddr  = req_addr;
                  inrange_in = req_inrange;
                  state_in   = ST_RD_OUT;
               end else begin
                  iss_pend_in = 1'b1;
                  iss_addr_in = AW'(fgr_pkg::BOTTOM_BASE);
                  iss_col_in  = '0;
                  proc_vld_in = 1'b0;
                  attempt_in  = 1'b0;
                  state_in    = ST_SWEEP;
               end
            end
         end
         ST_RD_OUT: begin
            rd_rsp.valid     = slot_free;
            rd_rsp.glyph     = inrange_ff ? rdata_ff.glyph : '0;
            rd_rsp.remaining = inrange_ff ? rdata_ff.count : '0;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            // streak head over an empty cell: draw a glyph before committing
            if (need_draw && !rand_rsp.done && !rand_rsp.busy) begin
               rand_req.start = 1'b1;
               rand_req.op    = fgr_pkg::OP_GLYPH;
            end
            if (commit) begin
               shift_en = 1'b1;
               if (!bottom) begin
                  mem_we    = 1'b1;
                  mem_waddr = proc_addr_ff + AW'(fgr_pkg::GRID_COLS);
                  mem_wdata = new_below;
               end
               if (proc_addr_ff == AW'(fgr_pkg::GRID_COLS - 1)) begin
                  flush_col_in = '0;
                  state_in     = ST_FLUSH;
               end
            end
            if (issue) begin
               mem_re       = 1'b1;
               mem_raddr    = iss_addr_ff;
               proc_addr_in = iss_addr_ff;
               if (iss_col_ff == CW'(fgr_pkg::GRID_COLS - 1)) begin
                  iss_col_in  = '0;
                  iss_addr_in = iss_addr_ff + AW'(1) - AW'(2 * fgr_pkg::GRID_COLS);
               end else begin
                  iss_col_in  = iss_col_ff + CW'(1);
                  iss_addr_in = iss_addr_ff + AW'(1);
               end
               if (iss_addr_ff == AW'(fgr_pkg::GRID_COLS - 1)) begin
                  iss_pend_in = 1'b0;
               end
            end
            if (commit || !proc_vld_ff) begin
               proc_vld_in = issue;
            end
         end
         ST_FLUSH: begin
            mem_we       = 1'b1;
            mem_waddr    = AW'(flush_col_ff);
            mem_wdata    = head;
            shift_en     = 1'b1;
            flush_col_in = flush_col_ff + CW'(1);
            if (flush_col_ff == CW'(fgr_pkg::GRID_COLS - 1)) begin
               state_in = ST_SP_COL;
            end
         end
         ST_SP_COL: begin
            if (rand_rsp.done) begin
               sp_col_in = rand_rsp.value[CW-1:0];
               state_in  = ST_SP_RD0;
            end else if (!rand_rsp.busy) begin
               rand_req.start = 1'b1;
               rand_req.op    = fgr_pkg::OP_COL;
            end
         end
         ST_SP_RD0: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(sp_col_ff);
            state_in  = ST_SP_RD1;
         end
         ST_SP_RD1: begin
            mem_re      = 1'b1;
            mem_raddr   = AW'(sp_col_ff) + AW'(fgr_pkg::GRID_COLS);
            top_live_in = rdata_ff.count != '0;
            state_in    = ST_SP_CHK;
         end
         ST_SP_CHK: begin
            if (top_live_ff || rdata_ff.count != '0) begin
               attempt_in = 1'b1;
               state_in   = attempt_ff ? ST_IDLE : ST_SP_COL;
            end else begin
               state_in = ST_SP_LEN;
            end
         end
         ST_SP_LEN: begin
            if (rand_rsp.done) begin
               len_in   = rand_rsp.value[fgr_pkg::CNT_W-1:0];
               state_in = ST_SP_GLY;
            end else if (!rand_rsp.busy) begin
               rand_req.start = 1'b1;
               rand_req.op    = fgr_pkg::OP_LEN;
            end
         end
         ST_SP_GLY: begin
            if (rand_rsp.done) begin
               mem_we          = 1'b1;
               mem_waddr       = AW'(sp_col_ff);
               mem_wdata.count = len_ff;
               mem_wdata.glyph = rand_rsp.value[fgr_pkg::GLYPH_W-1:0];
               attempt_in      = 1'b1;
               state_in        = attempt_ff ? ST_IDLE : ST_SP_COL;
            end else if (!rand_rsp.busy) begin
               rand_req.start = 1'b1;
               rand_req.op    = fgr_pkg::OP_GLYPH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = state_ff == ST_IDLE;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int k = 0; k < fgr_pkg::GRID_COLS - 1; k++) begin
            rowbuf_ff[k] <= rowbuf_ff[k+1];
         end
         rowbuf_ff[fgr_pkg::GRID_COLS-1] <= shift_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         iss_pend_ff <= 1'b0;
         proc_vld_ff <= 1'b0;
         attempt_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         iss_pend_ff <= iss_pend_in;
         proc_vld_ff <= proc_vld_in;
         attempt_ff  <= attempt_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_addr_ff  <= iss_addr_in;
      iss_col_ff   <= iss_col_in;
      proc_addr_ff <= proc_addr_in;
      flush_col_ff <= flush_col_in;
      sp_col_ff    <= sp_col_in;
      top_live_ff  <= top_live_in;
      len_ff       <= len_in;
      inrange_ff   <= inrange_in;
   end

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      rand_req.start |-> !rand_rsp.busy && !rand_rsp.done)
      else $error("random draw started while unit occupied");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> mem_waddr != mem_raddr)
      else $error("cell write and read hit the same entry");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      rand_rsp.done |-> (state_ff == ST_SWEEP || state_ff == ST_SP_COL ||
                         state_ff == ST_SP_LEN || state_ff == ST_SP_GLY))
      else $error("random result arrived with no consumer");

   a_sweep_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req.accept && req.cmd == fgr_pkg::CMD_TICK)
      |=> state_ff == ST_SWEEP && iss_pend_ff && !proc_vld_ff)
      else $error("tick did not start a sweep");
`endif

endmodule

@@ design/falling_glyph_rain_grid_unit.sv @@
// ----------------------------------------------------------------------------
// falling_glyph_rain_grid_unit
// Falling glyph rain grid: tick and cell read requests over a stream port.
// ----------------------------------------------------------------------------
// After reset the block clears the whole cell memory and takes no request
// until then. A read request gives one result; the result waits in an
// output register while later requests are taken. A tick request gives no
// result: one pass loads the bottom row into a row buffer, the sweep then
// handles one cell per cycle from the cell memory, reading one cell and
// writing another in the same cycle, a flush writes the top row back, and
// two spawn attempts follow; each random draw holds the sweep or the spawn
// while the serial remainder unit runs 16 steps.
// ----------------------------------------------------------------------------
module falling_glyph_rain_grid_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,   // row[4:0], col[10:5]
   input  logic [0:0]                 req_tuser,   // cmd[0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // glyph[6:0], remaining[10:7]
   input  logic                       csr_we,
   input  logic [fgr_pkg::CSR_AW-1:0] csr_addr,
   input  logic [fgr_pkg::CFG_W-1:0]  csr_wdata
);

   logic [fgr_pkg::CFG_W-1:0] min_length_ff, min_length_in;
   logic [fgr_pkg::CFG_W-1:0] length_span_ff, length_span_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [15:0]               rsp_data_ff, rsp_data_in;

   fgr_pkg::eng_req_type  eng_req;
   fgr_pkg::rd_rsp_type   rd_rsp;
   fgr_pkg::rand_req_type rand_req;
   fgr_pkg::rand_rsp_type rand_rsp;
   logic                  eng_ready;
   logic                  slot_free;

   assign req_tready     = eng_ready;
   assign eng_req.accept = req_tvalid && eng_ready;
   assign eng_req.cmd    = req_tuser[0];
   assign eng_req.row    = req_tdata[4:0];
   assign eng_req.col    = req_tdata[10:5];

   assign slot_free = !rsp_valid_ff || rsp_tready;

   fgr_rand u_rand (
      .clock       (clock),
      .reset       (reset),
      .rand_req    (rand_req),
      .min_length  (min_length_ff),
      .length_span (length_span_ff),
      .rand_rsp    (rand_rsp)
   );

   fgr_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (eng_req),
      .req_ready (eng_ready),
      .slot_free (slot_free),
      .rd_rsp    (rd_rsp),
      .rand_req  (rand_req),
      .rand_rsp  (rand_rsp)
   );

   always_comb begin
      min_length_in  = min_length_ff;
      length_span_in = length_span_ff;
      if (csr_we) begin
         unique case (csr_addr)
            fgr_pkg::CSR_MIN_LENGTH:  min_length_in  = csr_wdata;
            fgr_pkg::CSR_LENGTH_SPAN: length_span_in = csr_wdata;
            default: ;
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rd_rsp.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0, rd_rsp.remaining, rd_rsp.glyph};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff  <= fgr_pkg::CFG_W'(5);
         length_span_ff <= fgr_pkg::CFG_W'(11);
         rsp_valid_ff   <= 1'b0;
      end else begin
         min_length_ff  <= min_length_in;
         length_span_ff <= length_span_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ tb/sv/tb_falling_glyph_rain_grid_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_falling_glyph_rain_grid_unit
// Self-checking bench for the falling glyph rain grid.
// Tick and cell read requests go in over the request stream. A cycle-free
// model of the grid, its random sequence and its two length registers
// follows every accepted request and predicts each read result. The bench
// walks the registers through several settings, the extremes among them,
// and mixes sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_falling_glyph_rain_grid_unit;
   import fgr_pkg::*;

   localparam int CLK_HALF       = 4;
   localparam int SETTLE_CYCLES  = 6000;
   localparam int TAIL_CYCLES    = 6000;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int HOLD_CYCLES    = 400;
   localparam int CHUNK_ITEMS    = 17;
   localparam int PRESSURE_READS = 30;
   localparam int N_SETTINGS     = 8;

   typedef struct packed {
      logic                cmd;
      logic [ROW_IN_W-1:0] row;
      logic [COL_IN_W-1:0] col;
   } grid_request_t;

   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic [CNT_W-1:0]   remaining;
   } cell_view_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;    // row[4:0], col[10:5]
   logic [0:0]          req_tuser = '0;    // cmd[0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [15:0]         rsp_tdata;         // glyph[6:0], remaining[10:7]
   logic                csr_we = 1'b0;
   logic [CSR_AW-1:0]   csr_addr = '0;
   logic [CFG_W-1:0]    csr_wdata = '0;

   // grid model state
   logic [CNT_W-1:0]    rain_cnt   [CELLS];
   logic [GLYPH_W-1:0]  rain_glyph [CELLS];
   logic [LFSR_W-1:0]   rain_lfsr;
   logic [CFG_W-1:0]    rain_min_len;
   logic [CFG_W-1:0]    rain_span;

   grid_request_t       pending_q[$];
   cell_view_t          cell_expect_q[$];

   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  hold_asked = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;
   int                  quiet_cycles = 0;
   int                  mismatches = 0;
   int                  ticks_taken = 0;
   int                  reads_taken = 0;
   int                  results_checked = 0;

   falling_glyph_rain_grid_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [LFSR_W-1:0] lfsr_advance();
      logic fb;
      fb = rain_lfsr[0] ^ rain_lfsr[2] ^ rain_lfsr[3] ^ rain_lfsr[5];
      rain_lfsr = {fb, rain_lfsr[LFSR_W-1:1]};
      return rain_lfsr;
   endfunction

   function automatic logic [GLYPH_W-1:0] pick_glyph();
      int v;
      void'(lfsr_advance());
      void'(lfsr_advance());
      v = int'(lfsr_advance());
      return GLYPH_W'(v % GLYPH_MOD + GLYPH_BASE);
   endfunction

   function automatic void fade_cell(input int i);
      rain_cnt[i] = rain_cnt[i] - 1'b1;
      if (rain_cnt[i] == 0)
         rain_glyph[i] = '0;
   endfunction

   function automatic void try_spawn();
      int x;
      int span;
      int len;
      void'(lfsr_advance());
      void'(lfsr_advance());
      void'(lfsr_advance());
      x = int'(lfsr_advance()) % GRID_COLS;
      if (rain_cnt[x] != 0 || rain_cnt[GRID_COLS + x] != 0)
         return;
      span = (rain_span == 0) ? 1 : int'(rain_span);
      len = int'(lfsr_advance()) % span + int'(rain_min_len);
      if (len > CNT_MAX)
         len = CNT_MAX;
      rain_cnt[x] = CNT_W'(len);
      rain_glyph[x] = pick_glyph();
   endfunction

   function automatic void advance_frame();
      int i;
      int below;
      for (int x = 0; x < GRID_COLS; x++) begin
         if (rain_cnt[BOTTOM_BASE + x] != 0)
            fade_cell(BOTTOM_BASE + x);
      end
      for (int y = GRID_ROWS - 2; y >= 0; y--) begin
         for (int x = 0; x < GRID_COLS; x++) begin
            i = y * GRID_COLS + x;
            if (rain_cnt[i] != 0) begin
               below = i + GRID_COLS;
               if (rain_cnt[below] == 0)
                  rain_glyph[below] = pick_glyph();
               rain_cnt[below] = rain_cnt[i];
               fade_cell(i);
            end
         end
      end
      try_spawn();
      try_spawn();
   endfunction

   function automatic cell_view_t look_up_cell(input logic [ROW_IN_W-1:0] row_in,
                                               input logic [COL_IN_W-1:0] col_in);
      cell_view_t view;
      int i;
      view = '0;
      if (row_in < GRID_ROWS && col_in < GRID_COLS) begin
         i = int'(row_in) * GRID_COLS + int'(col_in);
         view.glyph = rain_glyph[i];
         view.remaining = rain_cnt[i];
      end
      return view;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      mismatches++;
   endtask

   // watches both channels: results are checked first, then the request is
   // applied to the grid model
   always @(posedge clock) begin
      cell_view_t want;
      logic [ROW_IN_W-1:0] row_in;
      logic [COL_IN_W-1:0] col_in;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (cell_expect_q.size() == 0) begin
               report_mismatch("result with no read pending", 0, int'(rsp_tdata));
            end else begin
               want = cell_expect_q.pop_front();
               results_checked++;
               if (rsp_tdata[GLYPH_W-1:0] !== want.glyph)
                  report_mismatch("glyph", want.glyph, rsp_tdata[GLYPH_W-1:0]);
               if (rsp_tdata[GLYPH_W +: CNT_W] !== want.remaining)
                  report_mismatch("remaining", want.remaining, rsp_tdata[GLYPH_W +: CNT_W]);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == CMD_TICK) begin
               advance_frame();
               ticks_taken++;
            end else begin
               row_in = req_tdata[ROW_IN_W-1:0];
               col_in = req_tdata[ROW_IN_W +: COL_IN_W];
               cell_expect_q.push_back(look_up_cell(row_in, col_in));
               reads_taken++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- driving

   always @(posedge clock) begin
      grid_request_t nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            nxt = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= 16'({nxt.col, nxt.row});
            req_tuser <= nxt.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_asked;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= stall_pct);
   end

   // ---------------------------------------------------------------- stimulus

   function automatic grid_request_t read_request(input int row_in, input int col_in);
      grid_request_t item;
      item.cmd = CMD_READ;
      item.row = ROW_IN_W'(row_in);
      item.col = COL_IN_W'(col_in);
      return item;
   endfunction

   function automatic grid_request_t tick_request();
      grid_request_t item;
      item.cmd = CMD_TICK;
      item.row = ROW_IN_W'($urandom_range(31, 0));
      item.col = COL_IN_W'($urandom_range(63, 0));
      return item;
   endfunction

   function automatic grid_request_t random_request();
      int pick;
      int row_in;
      int col_in;
      pick = $urandom_range(99, 0);
      if (pick < 20)
         return tick_request();
      if (pick < 28) begin
         row_in = $urandom_range(31, 0);
         col_in = $urandom_range(63, 0);
         if (row_in < GRID_ROWS && col_in < GRID_COLS) begin
            if ($urandom_range(1, 0) == 0)
               row_in = $urandom_range(31, GRID_ROWS);
            else
               col_in = $urandom_range(63, GRID_COLS);
         end
         return read_request(row_in, col_in);
      end
      if (pick < 64)
         row_in = $urandom_range(5, 0);
      else
         row_in = $urandom_range(GRID_ROWS - 1, 0);
      col_in = $urandom_range(GRID_COLS - 1, 0);
      return read_request(row_in, col_in);
   endfunction

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_tvalid || cell_expect_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_MIN_LENGTH:  rain_min_len = val;
         CSR_LENGTH_SPAN: rain_span = val;
         default: ;
      endcase
   endtask

   task automatic run_random_phase();
      int send_mode  [4] = '{0, 72, 0, 18};
      int stall_mode [4] = '{0, 0, 72, 18};
      for (int m = 0; m < 4; m++) begin
         send_idle_pct = send_mode[m];
         stall_pct = stall_mode[m];
         for (int k = 0; k < CHUNK_ITEMS; k++)
            pending_q.push_back(random_request());
         while (pending_q.size() != 0)
            @(negedge clock);
      end
      wait_idle();
   endtask

   initial begin
      int min_set  [N_SETTINGS] = '{5, 1, 15, 0, 0, 15, 3, 7};
      int span_set [N_SETTINGS] = '{11, 1, 15, 0, 15, 1, 4, 9};
      rain_lfsr = LFSR_SEED;
      rain_min_len = 4'd5;
      rain_span = 4'd11;
      for (int i = 0; i < CELLS; i++) begin
         rain_cnt[i] = '0;
         rain_glyph[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, out-of-range reads, ticks from an empty grid
      pending_q.push_back(read_request(0, 0));
      pending_q.push_back(read_request(GRID_ROWS - 1, GRID_COLS - 1));
      pending_q.push_back(read_request(31, 63));
      pending_q.push_back(read_request(GRID_ROWS, 0));
      pending_q.push_back(read_request(0, GRID_COLS));
      pending_q.push_back(read_request(GRID_ROWS - 1, 63));
      pending_q.push_back(tick_request());
      pending_q.push_back(read_request(0, 0));
      pending_q.push_back(tick_request());
      pending_q.push_back(tick_request());
      pending_q.push_back(tick_request());
      for (int c = 0; c < 8; c++)
         pending_q.push_back(read_request(c % 3, c * 5 + 2));
      pending_q.push_back(read_request(0, GRID_COLS - 1));
      pending_q.push_back(read_request(GRID_ROWS - 1, 0));
      pending_q.push_back(read_request(12, 31));
      wait_idle();

      // receiver holds off while reads keep coming, so the block backs up
      hold_asked = hold_asked + 1;
      for (int k = 0; k < PRESSURE_READS; k++)
         pending_q.push_back(read_request($urandom_range(3, 0),
                                          $urandom_range(GRID_COLS - 1, 0)));
      wait_idle();

      for (int s = 0; s < N_SETTINGS; s++) begin
         if (s != 0) begin
            repeat (SETTLE_CYCLES) @(negedge clock);
            write_csr(CSR_MIN_LENGTH, CFG_W'(min_set[s]));
            write_csr(CSR_LENGTH_SPAN, CFG_W'(span_set[s]));
         end
         run_random_phase();
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (cell_expect_q.size() != 0)
         report_mismatch("reads left without result", 0, cell_expect_q.size());

      $display("covered %0d ticks and %0d reads over %0d length settings, %0d results checked",
               ticks_taken, reads_taken, N_SETTINGS, results_checked);
      $display("idling: none, sender gaps, receiver stalls, both, plus one long hold-off");
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
